// ----- hdl/uart_packet_deframer_ring_queue_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the packet deframer
// Clocked, reset-qualified property shorthands.
// ----------------------------------------------------------------------------
`ifndef UART_PACKET_DEFRAMER_RING_QUEUE_MACROS_SVH
`define UART_PACKET_DEFRAMER_RING_QUEUE_MACROS_SVH

// same-cycle implication
`define UPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("upd assertion failed");

// next-cycle implication
`define UPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("upd assertion failed");

`endif

// ----- hdl/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types and constants for the packet deframer with ring queue.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam int QUEUE_DEPTH    = 128;
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_EXTRA    = 2'd2;

    localparam logic [7:0] RST_PREAMBLE_FIRST  = 8'd170;
    localparam logic [7:0] RST_PREAMBLE_SECOND = 8'd85;
    localparam logic [7:0] RST_HEADER_EXTRA    = 8'd1;

    localparam logic ACT_RECEIVE = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    typedef struct packed {
        logic [7:0] preamble_first;
        logic [7:0] preamble_second;
        logic [7:0] header_extra;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic       is_read;
        logic       push;
        logic       done;
        logic       fs_idle;
        logic [7:0] rx_byte;
    } t_cmd;

endpackage

// ----- hdl/upd_ifs.sv -----
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for receive/read items, results and config writes.
// ----------------------------------------------------------------------------
interface upd_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, action, rx_byte, input ready);
    modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       last_of_packet;
    logic       packet_done;
    logic       refused;
    logic       overflow;
    logic [7:0] packets_waiting;

    modport source (output valid, data_out, last_of_packet, packet_done, refused,
                    overflow, packets_waiting, input ready);
    modport sink   (input valid, data_out, last_of_packet, packet_done, refused,
                    overflow, packets_waiting, output ready);
endinterface

interface upd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [upd_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/upd_front.sv -----
// ----------------------------------------------------------------------------
// upd_front
// Accepts items, runs the preamble/size framing FSM, emits commands.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_action,
    input  logic [7:0]    i_rx_byte,
    input  upd_pkg::t_cfg i_cfg,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output upd_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_PREAMBLE = 4'b0010,
        ST_SIZE     = 4'b0100,
        ST_DATA     = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [7:0] r_remaining, n_remaining;
    logic [7:0] w_len;
    logic       w_accept;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign w_accept    = i_valid && i_cmd_ready;

    always_comb begin
        n_state         = r_state;
        n_remaining     = r_remaining;
        w_len           = r_remaining;
        o_cmd.is_read   = i_action;
        o_cmd.push      = 1'b0;
        o_cmd.done      = 1'b0;
        o_cmd.fs_idle   = (r_state == ST_IDLE);
        o_cmd.rx_byte   = i_rx_byte;
        if (i_action == upd_pkg::ACT_RECEIVE) begin
            case (r_state)
                ST_IDLE: begin
                    if (i_rx_byte == i_cfg.preamble_first) begin
                        n_state = ST_PREAMBLE;
                    end
                end
                ST_PREAMBLE: begin
                    n_state = (i_rx_byte == i_cfg.preamble_second) ? ST_SIZE : ST_IDLE;
                end
                ST_SIZE, ST_DATA: begin
                    o_cmd.push = 1'b1;
                    if (r_state == ST_SIZE) begin
                        w_len = i_rx_byte + i_cfg.header_extra;
                    end
                    n_remaining = w_len - 8'd1;
                    if (n_remaining == 8'd0) begin
                        n_state    = ST_IDLE;
                        o_cmd.done = 1'b1;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_remaining <= 8'd0;
        end else if (w_accept) begin
            r_state     <= n_state;
            r_remaining <= n_remaining;
        end
    end

endmodule

// ----- hdl/upd_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// upd_cmd_fifo
// Short command queue decoupling the framing front from the queue back.
// ----------------------------------------------------------------------------
module upd_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  upd_pkg::t_cmd i_wr_data,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output upd_pkg::t_cmd o_rd_data
);

    localparam int DEPTH = upd_pkg::CMD_FIFO_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    upd_pkg::t_cmd r_buf [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push, w_pop;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_wr_ready = (r_count != CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_buf[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/upd_back.sv -----
// ----------------------------------------------------------------------------
// upd_back
// Ring queue, packet read logic, packet counter and result register.
// ----------------------------------------------------------------------------
module upd_back #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  upd_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  upd_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_data_out,
    output logic          o_last_of_packet,
    output logic          o_packet_done,
    output logic          o_refused,
    output logic          o_overflow,
    output logic [7:0]    o_packets_waiting
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [7:0]             r_mem [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_written;
    logic [IW-1:0]          r_head, n_head;
    logic [IW-1:0]          r_tail, n_tail;
    logic [7:0]             r_rd_data;
    logic                   r_rd_written;
    logic                   r_byp;
    logic [7:0]             r_byp_data;
    logic                   r_read_active, n_read_active;
    logic [7:0]             r_read_rem, n_read_rem;
    logic [7:0]             r_counter, n_counter;

    logic                   r_out_valid;
    logic [7:0]             r_data, n_data;
    logic                   r_last, n_last;
    logic                   r_done, n_done;
    logic                   r_refused, n_refused;
    logic                   r_ovf, n_ovf;

    logic                   w_fire;
    logic                   w_wr_en;
    logic [7:0]             w_front;
    logic [7:0]             w_rem;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] p);
        return (p == IW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_fire      = i_cmd_valid && (!r_out_valid || i_ready);
    assign o_cmd_ready = w_fire;
    assign w_front     = r_byp ? r_byp_data : (r_rd_written ? r_rd_data : 8'd0);

    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_read_active = r_read_active;
        n_read_rem    = r_read_rem;
        n_counter     = r_counter;
        n_data        = 8'd0;
        n_last        = 1'b0;
        n_done        = 1'b0;
        n_refused     = 1'b0;
        n_ovf         = 1'b0;
        w_wr_en       = 1'b0;
        w_rem         = r_read_rem;
        if (w_fire) begin
            if (!i_cmd.is_read) begin
                if (i_cmd.push) begin
                    w_wr_en = 1'b1;
                    n_tail  = f_next(r_tail);
                    if (n_tail == r_head) begin
                        n_head = f_next(r_head);
                        n_ovf  = 1'b1;
                    end
                end
                if (i_cmd.done) begin
                    n_counter = r_counter + 8'd1;
                    n_done    = 1'b1;
                end
            end else if (!r_read_active && !i_cmd.fs_idle) begin
                n_refused = 1'b1;
            end else begin
                if (!r_read_active) begin
                    w_rem         = w_front + i_cfg.header_extra;
                    n_read_active = 1'b1;
                end
                n_read_rem = w_rem;
                if (w_rem != 8'd0) begin
                    if (r_head != r_tail) begin
                        n_data = w_front;
                        n_head = f_next(r_head);
                    end
                    n_read_rem = w_rem - 8'd1;
                end
                if (n_read_rem == 8'd0) begin
                    n_read_active = 1'b0;
                    n_last        = 1'b1;
                    n_counter     = r_counter - 8'd1;
                end
            end
        end
    end

    // queue storage; front byte is prefetched for the next head
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_tail] <= i_cmd.rx_byte;
        end
        r_rd_data  <= r_mem[n_head];
        r_byp_data <= i_cmd.rx_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written     <= '0;
            r_rd_written  <= 1'b0;
            r_byp         <= 1'b0;
            r_head        <= '0;
            r_tail        <= '0;
            r_read_active <= 1'b0;
            r_read_rem    <= 8'd0;
            r_counter     <= 8'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_written[r_tail] <= 1'b1;
            end
            r_rd_written  <= r_written[n_head];
            r_byp         <= w_wr_en && (r_tail == n_head);
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_read_active <= n_read_active;
            r_read_rem    <= n_read_rem;
            r_counter     <= n_counter;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_data    <= n_data;
            r_last    <= n_last;
            r_done    <= n_done;
            r_refused <= n_refused;
            r_ovf     <= n_ovf;
        end
    end

    logic [7:0] r_waiting;
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_waiting <= n_counter;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_data_out        = r_data;
    assign o_last_of_packet  = r_last;
    assign o_packet_done     = r_done;
    assign o_refused         = r_refused;
    assign o_overflow        = r_ovf;
    assign o_packets_waiting = r_waiting;

endmodule

// ----- hdl/uart_packet_deframer_ring_queue.sv -----
// ----------------------------------------------------------------------------
// uart_packet_deframer_ring_queue
// Preamble/size packet deframer feeding an overwriting byte ring queue.
//
// Channel  Dir  Payload                                         Transaction
// i_in     in   action, rx_byte                                 valid & ready
// o_out    out  data_out, last_of_packet, packet_done, refused, valid & ready
//               overflow, packets_waiting
// i_cfg    in   index, data (register write)                    valid & ready
//
// One item per cycle sustained; each result is registered. The back stage
// handles one command per cycle, set by the queue front-byte prefetch. Front
// stalls when the two-entry command queue is full; back stalls while the
// result register is held. Reset is synchronous; the queue is cleared at once
// through per-entry written bits, so no clearing pass runs.
// ----------------------------------------------------------------------------
module uart_packet_deframer_ring_queue #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    upd_in_if.sink          i_in,
    upd_out_if.source       o_out,
    upd_cfg_if.sink         i_cfg
);

    upd_pkg::t_cfg r_cfg;
    upd_pkg::t_cmd w_front_cmd, w_back_cmd;
    logic          w_front_valid, w_front_ready;
    logic          w_back_valid, w_back_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble_first  <= upd_pkg::RST_PREAMBLE_FIRST;
            r_cfg.preamble_second <= upd_pkg::RST_PREAMBLE_SECOND;
            r_cfg.header_extra    <= upd_pkg::RST_HEADER_EXTRA;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                upd_pkg::CFG_PREAMBLE_FIRST:  r_cfg.preamble_first  <= i_cfg.data;
                upd_pkg::CFG_PREAMBLE_SECOND: r_cfg.preamble_second <= i_cfg.data;
                upd_pkg::CFG_HEADER_EXTRA:    r_cfg.header_extra    <= i_cfg.data;
                default:                      r_cfg                 <= r_cfg;
            endcase
        end
    end

    upd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_action    (i_in.action),
        .i_rx_byte   (i_in.rx_byte),
        .i_cfg       (r_cfg),
        .o_cmd_valid (w_front_valid),
        .i_cmd_ready (w_front_ready),
        .o_cmd       (w_front_cmd)
    );

    upd_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_front_valid),
        .o_wr_ready (w_front_ready),
        .i_wr_data  (w_front_cmd),
        .o_rd_valid (w_back_valid),
        .i_rd_ready (w_back_ready),
        .o_rd_data  (w_back_cmd)
    );

    upd_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_cmd_valid       (w_back_valid),
        .o_cmd_ready       (w_back_ready),
        .i_cmd             (w_back_cmd),
        .o_valid           (o_out.valid),
        .i_ready           (o_out.ready),
        .o_data_out        (o_out.data_out),
        .o_last_of_packet  (o_out.last_of_packet),
        .o_packet_done     (o_out.packet_done),
        .o_refused         (o_out.refused),
        .o_overflow        (o_out.overflow),
        .o_packets_waiting (o_out.packets_waiting)
    );

endmodule

// ----- hdl/upd_checker.sv -----
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "uart_packet_deframer_ring_queue_macros.svh"

module upd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_data_out,
    input logic       i_last_of_packet,
    input logic       i_packet_done,
    input logic       i_refused,
    input logic       i_overflow,
    input logic [7:0] i_packets_waiting
);

    `UPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `UPD_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_data_out) && $stable(i_packets_waiting))
    `UPD_ASSERT_SAME(a_recv_read_excl, i_clk, i_rst_n, i_out_valid && (i_packet_done || i_overflow), !i_last_of_packet && !i_refused && (i_data_out == 8'd0))
    `UPD_ASSERT_SAME(a_refused_quiet, i_clk, i_rst_n, i_out_valid && i_refused, !i_last_of_packet && !i_packet_done && (i_data_out == 8'd0))

endmodule

bind uart_packet_deframer_ring_queue upd_checker u_upd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_data_out        (o_out.data_out),
    .i_last_of_packet  (o_out.last_of_packet),
    .i_packet_done     (o_out.packet_done),
    .i_refused         (o_out.refused),
    .i_overflow        (o_out.overflow),
    .i_packets_waiting (o_out.packets_waiting)
);
